// File: src/plc_port_frame_responder_assert.svh
// ----------------------------------------------------------------------------
// plc_port_frame_responder assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLC_PORT_FRAME_RESPONDER_ASSERT_SVH
`define PLC_PORT_FRAME_RESPONDER_ASSERT_SVH

// same-cycle implication
`define PFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfr: same-cycle check failed");

// next-cycle implication
`define PFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfr: next-cycle check failed");

`endif

// File: src/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Character codes, command/status types and hex helpers for the responder.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam logic [7:0] CH_ENQ  = 8'h05;
	localparam logic [7:0] CH_ACK  = 8'h06;
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_ETX  = 8'h03;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	// 'A' - 10
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

	localparam logic [7:0] FRAME_LIMIT_RESET = 8'd144;

	localparam int MAX_READ_BYTES = 29;
	// reply characters per read: two per byte
	localparam int CNT_W = $clog2(2 * MAX_READ_BYTES + 1);
	localparam logic [7:0] MAX_READ_BYTES_B = 8'(MAX_READ_BYTES);

	typedef enum logic [2:0] {
		OUT_ACK,
		OUT_STX,
		OUT_ZERO,
		OUT_ETX,
		OUT_HI,
		OUT_LO
	} out_sel_t;

	typedef struct packed {
		logic     start_frame;
		logic     take_body;
		logic     take_chk1;
		logic     start_reply;
		logic     load_out;
		out_sel_t out_sel;
		logic     out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic is_enq;
		logic is_stx;
		logic is_etx;
		logic over_limit;
		logic frame_ok;
		logic chars_done;
		logic out_free;
	} dp_sts_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'b0000, nib};
		return (nib > 4'd9) ? (wide + HEX_ALPHA_BASE) : (wide + CH_ZERO);
	endfunction

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) ? (c - CH_ZERO) : (c - HEX_ALPHA_BASE);
	endfunction

endpackage

// File: src/pfr_ctrl.sv
// ----------------------------------------------------------------------------
// pfr_ctrl
// Frame phase and reply sequencer; drives the datapath by commands.
// ----------------------------------------------------------------------------
module pfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pfr_pkg::dp_sts_t sts,
	output pfr_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BODY,
		ST_CHK1,
		ST_CHK2,
		ST_RSTX,
		ST_RDATA,
		ST_RHI,
		ST_RLO
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   frame_phase;
	logic   accept;

	always_comb begin
		frame_phase = state_q inside {ST_IDLE, ST_BODY, ST_CHK1, ST_CHK2};
		in_stall    = !(frame_phase && sts.out_free);
		accept      = in_valid && !in_stall;
	end

	always_comb begin
		cmd         = '0;
		cmd.out_sel = pfr_pkg::OUT_ACK;
		state_d     = state_q;
		case (state_q)
			ST_IDLE, ST_BODY, ST_CHK1, ST_CHK2: begin
				if (accept) begin
					if (sts.is_enq) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = pfr_pkg::OUT_ACK;
						cmd.out_last = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						case (state_q)
							ST_IDLE: begin
								if (sts.is_stx) begin
									cmd.start_frame = 1'b1;
									state_d         = ST_BODY;
								end
							end
							ST_BODY: begin
								cmd.take_body = 1'b1;
								if (sts.is_etx) begin
									state_d = ST_CHK1;
								end else if (sts.over_limit) begin
									state_d = ST_IDLE;
								end
							end
							ST_CHK1: begin
								cmd.take_chk1 = 1'b1;
								state_d       = ST_CHK2;
							end
							default: begin
								if (sts.frame_ok) begin
									cmd.start_reply = 1'b1;
									state_d         = ST_RSTX;
								end else begin
									state_d = ST_IDLE;
								end
							end
						endcase
					end
				end
			end
			ST_RSTX: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = pfr_pkg::OUT_STX;
					state_d      = ST_RDATA;
				end
			end
			ST_RDATA: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (sts.chars_done) begin
						cmd.out_sel = pfr_pkg::OUT_ETX;
						state_d     = ST_RHI;
					end else begin
						cmd.out_sel = pfr_pkg::OUT_ZERO;
					end
				end
			end
			ST_RHI: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = pfr_pkg::OUT_HI;
					state_d      = ST_RLO;
				end
			end
			ST_RLO: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = pfr_pkg::OUT_LO;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/pfr_dp.sv
// ----------------------------------------------------------------------------
// pfr_dp
// Frame capture registers, checksum, reply counter and output register.
// ----------------------------------------------------------------------------
module pfr_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  pfr_pkg::dp_cmd_t cmd,
	output pfr_pkg::dp_sts_t sts,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [7:0]       tx_byte,
	output logic             last_of_reply
);

	logic [7:0]               frame_limit_q;
	logic [7:0]               body_count_q;
	logic [7:0]               running_sum_q;
	logic [7:0]               first_check_q;
	logic [7:0]               command_q;
	logic [7:0]               size_hi_q;
	logic [7:0]               size_lo_q;
	logic [pfr_pkg::CNT_W-1:0] chars_left_q;
	logic [7:0]               reply_sum_q;
	logic                     out_valid_q;
	logic [7:0]               tx_byte_q;
	logic                     last_q;

	logic [8:0]               next_count;
	logic [7:0]               dv_hi;
	logic [7:0]               dv_lo;
	logic [7:0]               size_raw;
	logic [7:0]               size_clamp;
	logic [pfr_pkg::CNT_W-1:0] reply_chars;
	logic [7:0]               out_byte;

	always_comb begin
		next_count = {1'b0, body_count_q} + 9'd1;
		dv_hi      = pfr_pkg::digit_value(size_hi_q);
		dv_lo      = pfr_pkg::digit_value(size_lo_q);
		size_raw   = {dv_hi[3:0], 4'b0000} | dv_lo;
		size_clamp = (size_raw > pfr_pkg::MAX_READ_BYTES_B) ? pfr_pkg::MAX_READ_BYTES_B
			: size_raw;
		reply_chars = {size_clamp[pfr_pkg::CNT_W-2:0], 1'b0};

		sts.is_enq     = rx_byte == pfr_pkg::CH_ENQ;
		sts.is_stx     = rx_byte == pfr_pkg::CH_STX;
		sts.is_etx     = rx_byte == pfr_pkg::CH_ETX;
		sts.over_limit = next_count > {1'b0, frame_limit_q};
		sts.frame_ok   = (first_check_q == pfr_pkg::hex_char(running_sum_q[7:4]))
			&& (rx_byte == pfr_pkg::hex_char(running_sum_q[3:0]))
			&& (command_q == pfr_pkg::CH_ZERO);
		sts.chars_done = chars_left_q == '0;
		sts.out_free   = !out_valid_q || !out_stall;

		case (cmd.out_sel)
			pfr_pkg::OUT_ACK:  out_byte = pfr_pkg::CH_ACK;
			pfr_pkg::OUT_STX:  out_byte = pfr_pkg::CH_STX;
			pfr_pkg::OUT_ZERO: out_byte = pfr_pkg::CH_ZERO;
			pfr_pkg::OUT_ETX:  out_byte = pfr_pkg::CH_ETX;
			pfr_pkg::OUT_HI:   out_byte = pfr_pkg::hex_char(reply_sum_q[7:4]);
			pfr_pkg::OUT_LO:   out_byte = pfr_pkg::hex_char(reply_sum_q[3:0]);
			default:           out_byte = pfr_pkg::CH_ACK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= pfr_pkg::FRAME_LIMIT_RESET;
			body_count_q  <= '0;
			running_sum_q <= '0;
			first_check_q <= '0;
			command_q     <= '0;
			size_hi_q     <= '0;
			size_lo_q     <= '0;
			chars_left_q  <= '0;
			reply_sum_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_limit_q <= cfg_wdata;
			end
			if (cmd.start_frame) begin
				body_count_q  <= '0;
				running_sum_q <= '0;
			end
			if (cmd.take_body) begin
				if (body_count_q == 8'd0) begin
					command_q <= rx_byte;
				end else if (body_count_q == 8'd5) begin
					size_hi_q <= rx_byte;
				end else if (body_count_q == 8'd6) begin
					size_lo_q <= rx_byte;
				end
				running_sum_q <= running_sum_q + rx_byte;
				// saturate at the top of the count
				body_count_q  <= next_count[8] ? 8'hFF : next_count[7:0];
			end
			if (cmd.take_chk1) begin
				first_check_q <= rx_byte;
			end
			if (cmd.start_reply) begin
				chars_left_q <= reply_chars;
				reply_sum_q  <= '0;
			end else if (cmd.load_out && cmd.out_sel == pfr_pkg::OUT_ZERO) begin
				chars_left_q <= chars_left_q - 1'b1;
				reply_sum_q  <= reply_sum_q + pfr_pkg::CH_ZERO;
			end else if (cmd.load_out && cmd.out_sel == pfr_pkg::OUT_ETX) begin
				reply_sum_q <= reply_sum_q + pfr_pkg::CH_ETX;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tx_byte_q <= out_byte;
			last_q    <= cmd.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_byte       = tx_byte_q;
	assign last_of_reply = last_q;

endmodule

// File: src/plc_port_frame_responder.sv
// ----------------------------------------------------------------------------
// plc_port_frame_responder
// Byte-serial frame responder: ENQ/ACK and hex-checksummed read frames.
// ----------------------------------------------------------------------------
// Each received byte is taken while the block is in a frame
// phase and its output register is free or being emptied. An ENQ answers
// with ACK on the next cycle. The second check character of a valid read
// frame starts a reply of 2*N+4 bytes (N = requested size, at most 29),
// sent from the output register by the reply sequencer, one byte a cycle
// while out_stall is low; in_stall stays high until the last reply byte is
// loaded, so a read holds off input for the reply plus any out_stall time.
// frame_limit resets to 144 and is written through cfg_we/cfg_wdata.
module plc_port_frame_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       last_of_reply,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	`include "plc_port_frame_responder_assert.svh"

	pfr_pkg::dp_cmd_t cmd;
	pfr_pkg::dp_sts_t sts;

	logic enq_taken;
	logic ack_shown;
	logic last_code_ok;

	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.tx_byte       (tx_byte),
		.last_of_reply (last_of_reply)
	);

	always_comb begin
		enq_taken    = in_valid && !in_stall && rx_byte == pfr_pkg::CH_ENQ;
		ack_shown    = out_valid && tx_byte == pfr_pkg::CH_ACK && last_of_reply;
		last_code_ok = tx_byte == pfr_pkg::CH_ACK
			|| (tx_byte >= pfr_pkg::CH_ZERO && tx_byte <= pfr_pkg::CH_NINE)
			|| (tx_byte >= pfr_pkg::hex_char(4'hA) && tx_byte <= pfr_pkg::hex_char(4'hF));
	end

	// an accepted ENQ shows ACK as a single-byte reply next cycle
	`PFR_ASSERT_NXT(a_enq_ack, enq_taken, ack_shown)

	// no input is taken while a read reply is still unfinished
	`PFR_ASSERT_IMP(a_reply_blocks_input, out_valid && !last_of_reply, in_stall)

	// the closing byte is ACK or an upper-case hex digit
	`PFR_ASSERT_IMP(a_last_byte_code, out_valid && last_of_reply, last_code_ok)

endmodule
